@@ rtl/tickless_deadline_scheduler_unit_assert.svh @@
`ifndef TICKLESS_DEADLINE_SCHEDULER_UNIT_ASSERT_SVH
`define TICKLESS_DEADLINE_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication, checked on clk, off during reset
`define TDS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tds assertion failed");

// next-cycle implication
`define TDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tds assertion failed");

`endif

@@ rtl/tds_pkg.sv @@
package tds_pkg;

    localparam int NUM_SLOTS     = 16;
    localparam int DEADLINE_BITS = 16;
    localparam int SLOT_W        = $clog2(NUM_SLOTS);
    localparam int CNT_W         = $clog2(NUM_SLOTS + 1);
    localparam int CFG_W         = 5;
    localparam int KIND_W        = 2;

    localparam logic ACT_SCHEDULE = 1'b0;
    localparam logic ACT_EXPIRY   = 1'b1;

    localparam logic [KIND_W-1:0] KIND_FIRED   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELOAD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOPPED = 2'd2;

    typedef struct packed {
        logic                     en;
        logic [SLOT_W-1:0]        addr;
        logic [DEADLINE_BITS-1:0] deadline;
        logic                     armed;
    } wr_req_t;

    typedef struct packed {
        logic                     fire;
        logic                     wr;
        logic [DEADLINE_BITS-1:0] remain;
        logic [DEADLINE_BITS-1:0] min_val;
        logic                     have;
    } alu_out_t;

endpackage

@@ rtl/tds_scan_alu.sv @@
module tds_scan_alu (
    input  logic                               armed,
    input  logic [tds_pkg::DEADLINE_BITS-1:0]  deadline,
    input  logic [tds_pkg::DEADLINE_BITS-1:0]  ticks,
    input  logic [tds_pkg::DEADLINE_BITS-1:0]  cur_min,
    input  logic                               have,
    output tds_pkg::alu_out_t                  res
);

    logic [tds_pkg::DEADLINE_BITS:0]   diff;
    logic                              expired;
    logic [tds_pkg::DEADLINE_BITS-1:0] remain;

    // deadline <= ticks when the borrow is set or the difference is zero
    assign diff    = {1'b0, deadline} - {1'b0, ticks};
    assign expired = diff[tds_pkg::DEADLINE_BITS] || (diff[tds_pkg::DEADLINE_BITS-1:0] == '0);
    assign remain  = expired ? '0 : diff[tds_pkg::DEADLINE_BITS-1:0];

    always_comb
    begin
        res.fire    = armed && expired;
        res.wr      = armed;
        res.remain  = remain;
        res.min_val = cur_min;
        res.have    = have;
        if (armed && !expired)
        begin
            res.have = 1'b1;
            if (!have || (remain < cur_min))
            begin
                res.min_val = remain;
            end
        end
    end

endmodule

@@ rtl/tds_slot_store.sv @@
module tds_slot_store (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tds_pkg::wr_req_t                   wr,
    input  logic                               rd_en,
    input  logic [tds_pkg::SLOT_W-1:0]         rd_addr,
    output logic [tds_pkg::DEADLINE_BITS-1:0]  rd_deadline,
    output logic                               rd_armed
);

    logic [tds_pkg::DEADLINE_BITS-1:0] deadline_mem [tds_pkg::NUM_SLOTS];
    logic [tds_pkg::NUM_SLOTS-1:0]     armed_reg;
    logic [tds_pkg::DEADLINE_BITS-1:0] rd_deadline_reg;
    logic                              rd_armed_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            deadline_mem[wr.addr] <= wr.deadline;
        end
        if (rd_en)
        begin
            rd_deadline_reg <= deadline_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg    <= '0;
            rd_armed_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                armed_reg[wr.addr] <= wr.armed;
            end
            if (rd_en)
            begin
                rd_armed_reg <= armed_reg[rd_addr];
            end
        end
    end

    assign rd_deadline = rd_deadline_reg;
    assign rd_armed    = rd_armed_reg;

endmodule

@@ rtl/tickless_deadline_scheduler_unit.sv @@
// channel  | direction | transfer when          | signals
// ---------+-----------+------------------------+---------------------------------------------
// command  | in        | start & !busy          | action slot_index new_deadline arm
//          |           |                        | elapsed_ticks
// result   | out       | result_valid (1 cycle) | result_kind fired_slot reload_value last
// config   | in        | cfg_valid & cfg_ready  | cfg_data (tasks_in_use)
//
// An item scans min(tasks_in_use, 16) slots between start and busy low: a schedule command
// writes its slot at the transfer edge, then one slot per cycle goes through the shared
// compare/subtract unit behind the registered read of the deadline memory, then the final
// result is registered. Fired results appear in the cycle after their slot is evaluated;
// the final result sits on the ports in the cycle busy falls. Reset clears armed bits and
// sets tasks_in_use to 16. The receiver cannot stall; cfg_ready is high while idle.
`include "tickless_deadline_scheduler_unit_assert.svh"

module tickless_deadline_scheduler_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               action,
    input  logic [tds_pkg::SLOT_W-1:0]         slot_index,
    input  logic [tds_pkg::DEADLINE_BITS-1:0]  new_deadline,
    input  logic                               arm,
    input  logic [tds_pkg::DEADLINE_BITS-1:0]  elapsed_ticks,
    output logic                               result_valid,
    output logic [tds_pkg::KIND_W-1:0]         result_kind,
    output logic [tds_pkg::SLOT_W-1:0]         fired_slot,
    output logic [tds_pkg::DEADLINE_BITS-1:0]  reload_value,
    output logic                               last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tds_pkg::CFG_W-1:0]          cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINAL
    } state_t;

    state_t                            state_reg, state_next;
    logic [tds_pkg::CFG_W-1:0]         tasks_reg, tasks_next;
    logic [tds_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [tds_pkg::CNT_W-1:0]         issue_reg, issue_next;
    logic                              eval_valid_reg, eval_valid_next;
    logic [tds_pkg::SLOT_W-1:0]        eval_idx_reg, eval_idx_next;
    logic [tds_pkg::DEADLINE_BITS-1:0] ticks_reg, ticks_next;
    logic [tds_pkg::DEADLINE_BITS-1:0] min_reg, min_next;
    logic                              have_reg, have_next;
    logic                              rv_reg, rv_next;
    logic [tds_pkg::KIND_W-1:0]        kind_reg, kind_next;
    logic [tds_pkg::SLOT_W-1:0]        slot_reg, slot_next;
    logic [tds_pkg::DEADLINE_BITS-1:0] reload_reg, reload_next;
    logic                              last_reg, last_next;

    logic                              accept;
    logic [tds_pkg::CNT_W-1:0]         clamped;
    logic                              rd_en;
    logic [tds_pkg::DEADLINE_BITS-1:0] rd_deadline;
    logic                              rd_armed;
    tds_pkg::wr_req_t                  wr;
    tds_pkg::alu_out_t                 alu;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);

    assign clamped = (tasks_reg > tds_pkg::CFG_W'(tds_pkg::NUM_SLOTS))
                   ? tds_pkg::CNT_W'(tds_pkg::NUM_SLOTS)
                   : tds_pkg::CNT_W'(tasks_reg);

    assign rd_en = (state_reg == ST_SCAN) && (issue_reg < count_reg);

    tds_slot_store u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr          (wr),
        .rd_en       (rd_en),
        .rd_addr     (issue_reg[tds_pkg::SLOT_W-1:0]),
        .rd_deadline (rd_deadline),
        .rd_armed    (rd_armed)
    );

    tds_scan_alu u_alu (
        .armed    (rd_armed),
        .deadline (rd_deadline),
        .ticks    (ticks_reg),
        .cur_min  (min_reg),
        .have     (have_reg),
        .res      (alu)
    );

    always_comb
    begin
        wr.en       = 1'b0;
        wr.addr     = eval_idx_reg;
        wr.deadline = alu.remain;
        wr.armed    = 1'b0;
        if (accept)
        begin
            wr.en       = (action == tds_pkg::ACT_SCHEDULE);
            wr.addr     = slot_index;
            wr.deadline = new_deadline;
            wr.armed    = arm;
        end
        else if ((state_reg == ST_SCAN) && eval_valid_reg && alu.wr)
        begin
            wr.en    = 1'b1;
            wr.armed = !alu.fire;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        tasks_next      = tasks_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        eval_valid_next = 1'b0;
        eval_idx_next   = eval_idx_reg;
        ticks_next      = ticks_reg;
        min_next        = min_reg;
        have_next       = have_reg;
        rv_next         = 1'b0;
        kind_next       = tds_pkg::KIND_FIRED;
        slot_next       = '0;
        reload_next     = '0;
        last_next       = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            tasks_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ticks_next = elapsed_ticks;
                    count_next = clamped;
                    issue_next = '0;
                    min_next   = '0;
                    have_next  = 1'b0;
                    state_next = (clamped == '0) ? ST_FINAL : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    eval_valid_next = 1'b1;
                    eval_idx_next   = issue_reg[tds_pkg::SLOT_W-1:0];
                    issue_next      = issue_reg + tds_pkg::CNT_W'(1);
                end
                if (eval_valid_reg)
                begin
                    min_next  = alu.min_val;
                    have_next = alu.have;
                    if (alu.fire)
                    begin
                        rv_next   = 1'b1;
                        kind_next = tds_pkg::KIND_FIRED;
                        slot_next = eval_idx_reg;
                    end
                end
                if (issue_reg == count_reg)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                rv_next     = 1'b1;
                last_next   = 1'b1;
                kind_next   = have_reg ? tds_pkg::KIND_RELOAD : tds_pkg::KIND_STOPPED;
                reload_next = have_reg ? min_reg : '0;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tasks_reg      <= tds_pkg::CFG_W'(tds_pkg::NUM_SLOTS);
            count_reg      <= '0;
            issue_reg      <= '0;
            eval_valid_reg <= 1'b0;
            eval_idx_reg   <= '0;
            ticks_reg      <= '0;
            min_reg        <= '0;
            have_reg       <= 1'b0;
            rv_reg         <= 1'b0;
            kind_reg       <= tds_pkg::KIND_FIRED;
            slot_reg       <= '0;
            reload_reg     <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tasks_reg      <= tasks_next;
            count_reg      <= count_next;
            issue_reg      <= issue_next;
            eval_valid_reg <= eval_valid_next;
            eval_idx_reg   <= eval_idx_next;
            ticks_reg      <= ticks_next;
            min_reg        <= min_next;
            have_reg       <= have_next;
            rv_reg         <= rv_next;
            kind_reg       <= kind_next;
            slot_reg       <= slot_next;
            reload_reg     <= reload_next;
            last_reg       <= last_next;
        end
    end

    assign result_valid = rv_reg;
    assign result_kind  = kind_reg;
    assign fired_slot   = slot_reg;
    assign reload_value = reload_reg;
    assign last         = last_reg;

    `TDS_ASSERT_NEXT(a_final_emits, state_reg == ST_FINAL, result_valid && last)
    `TDS_ASSERT_NOW(a_last_kind, result_valid && last,
                    result_kind == tds_pkg::KIND_RELOAD || result_kind == tds_pkg::KIND_STOPPED)
    `TDS_ASSERT_NOW(a_fire_kind, result_valid && !last,
                    result_kind == tds_pkg::KIND_FIRED && reload_value == '0)
    `TDS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `TDS_ASSERT_NOW(a_issue_bound, state_reg == ST_SCAN, issue_reg <= count_reg)

endmodule
